>>> rtl/hts_pkg.sv
`timescale 1ns / 1ps
// shared types, codes, gait plan table and window compare for the tripod gait sequencer
// no dependencies
package hts_pkg;

  localparam int NLEGS      = 6;
  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int LAND_W     = 14;
  localparam int MAG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  typedef logic [1:0]            op_t;
  typedef logic [1:0]            phase_t;
  typedef logic [2:0]            win_t;
  typedef logic [1:0]            spd_t;
  typedef logic [1:0]            plan_idx_t;
  typedef logic [ANGLE_W-1:0]    angle_t;
  typedef logic [SPEED_W-1:0]    speed_t;
  typedef logic [LAND_W-1:0]     land_t;
  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam op_t OP_LEFT  = 2'd0;
  localparam op_t OP_STOP  = 2'd1;
  localparam op_t OP_RIGHT = 2'd2;
  localparam op_t OP_FWD   = 2'd3;

  localparam phase_t PH_HOME  = 2'd1;
  localparam phase_t PH_TRI_A = 2'd2;
  localparam phase_t PH_TRI_B = 2'd3;

  localparam plan_idx_t IDX_0 = 2'd0;
  localparam plan_idx_t IDX_1 = 2'd1;
  localparam plan_idx_t IDX_2 = 2'd2;

  localparam win_t W_HALF  = 3'd1;
  localparam win_t W_HOME  = 3'd2;
  localparam win_t W_LATE  = 3'd3;
  localparam win_t W_LAND  = 3'd4;
  localparam win_t W_REV   = 3'd5;
  localparam win_t W_EARLY = 3'd6;
  localparam win_t W_LHOME = 3'd7;

  localparam spd_t S_PA = 2'd0;
  localparam spd_t S_NA = 2'd1;
  localparam spd_t S_PG = 2'd2;
  localparam spd_t S_NG = 2'd3;

  localparam cfg_idx_t REG_LANDING = 2'd0;
  localparam cfg_idx_t REG_AIR     = 2'd1;
  localparam cfg_idx_t REG_GROUND  = 2'd2;

  localparam land_t LANDING_RST = 14'd3640;
  localparam mag_t  AIR_RST     = 15'd1792;
  localparam mag_t  GROUND_RST  = 15'd224;

  typedef struct packed {
    win_t win;
    spd_t spd;
  } plan_t;

  // [mode: left, right, forward][phase: home, tripod a, tripod b][leg]
  localparam plan_t PLAN [3][3][NLEGS] = '{
    '{
      '{'{W_HALF, S_PA}, '{W_HALF, S_NA}, '{W_HALF, S_PA},
        '{W_HOME, S_NA}, '{W_HOME, S_PA}, '{W_HOME, S_NA}},
      '{'{W_LATE, S_PA}, '{W_EARLY, S_NA}, '{W_LATE, S_PA},
        '{W_REV, S_NG}, '{W_LAND, S_PG}, '{W_REV, S_NG}},
      '{'{W_LAND, S_PG}, '{W_REV, S_NG}, '{W_LAND, S_PG},
        '{W_EARLY, S_NA}, '{W_LATE, S_PA}, '{W_EARLY, S_NA}}
    },
    '{
      '{'{W_HALF, S_NA}, '{W_HALF, S_PA}, '{W_HALF, S_NA},
        '{W_LHOME, S_PA}, '{W_EARLY, S_NA}, '{W_LHOME, S_PA}},
      '{'{W_EARLY, S_NA}, '{W_LATE, S_PA}, '{W_EARLY, S_NA},
        '{W_LAND, S_PG}, '{W_REV, S_NG}, '{W_LAND, S_PG}},
      '{'{W_REV, S_NG}, '{W_LAND, S_PG}, '{W_REV, S_NG},
        '{W_LATE, S_PA}, '{W_EARLY, S_NA}, '{W_LATE, S_PA}}
    },
    '{
      '{'{W_HALF, S_PA}, '{W_HALF, S_PA}, '{W_HALF, S_PA},
        '{W_HOME, S_PA}, '{W_HOME, S_PA}, '{W_HOME, S_PA}},
      '{'{W_LATE, S_PA}, '{W_LATE, S_PA}, '{W_LATE, S_PA},
        '{W_LAND, S_PG}, '{W_LAND, S_PG}, '{W_LAND, S_PG}},
      '{'{W_LAND, S_PG}, '{W_LAND, S_PG}, '{W_LAND, S_PG},
        '{W_LATE, S_PA}, '{W_LATE, S_PA}, '{W_LATE, S_PA}}
    }
  };

  // angle window test, 65536 per turn, compared on 17 bits
  function automatic logic in_window(win_t w, angle_t a, land_t l);
    logic [ANGLE_W:0] a17;
    logic [ANGLE_W:0] l17;
    logic [ANGLE_W:0] two_l;
    logic [ANGLE_W:0] turn_m_l;
    logic [ANGLE_W:0] turn_m_2l;
    logic             hit;
    a17       = {1'b0, a};
    l17       = {{(ANGLE_W + 1 - LAND_W){1'b0}}, l};
    two_l     = {l17[ANGLE_W-1:0], 1'b0};
    turn_m_l  = 17'h10000 - l17;
    turn_m_2l = 17'h10000 - two_l;
    case (w)
      W_HALF:  hit = a17 > 17'h08000;
      W_HOME:  hit = (a17 > l17) && (a17 < turn_m_2l);
      W_LATE:  hit = a17 > turn_m_l;
      W_LAND:  hit = (a17 > l17) && (a17 < two_l);
      W_REV:   hit = (a17 > two_l) && (a17 < turn_m_l);
      W_EARLY: hit = a17 < l17;
      default: hit = a17 > turn_m_2l;
    endcase
    return hit;
  endfunction

endpackage

>>> rtl/hts_in_if.sv
`timescale 1ns / 1ps
// input channel: gait mode and six leg angles with valid/ready
// depends on hts_pkg
interface hts_in_if;
  logic            valid;
  logic            ready;
  hts_pkg::op_t    op;
  hts_pkg::angle_t angle_0;
  hts_pkg::angle_t angle_1;
  hts_pkg::angle_t angle_2;
  hts_pkg::angle_t angle_3;
  hts_pkg::angle_t angle_4;
  hts_pkg::angle_t angle_5;

  modport source (output valid, op, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                  input ready);
  modport sink (input valid, op, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                output ready);
endinterface

>>> rtl/hts_out_if.sv
`timescale 1ns / 1ps
// result channel: six signed leg speeds and the gait phase with valid/ready
// depends on hts_pkg
interface hts_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    speed_0;
  logic signed [15:0]    speed_1;
  logic signed [15:0]    speed_2;
  logic signed [15:0]    speed_3;
  logic signed [15:0]    speed_4;
  logic signed [15:0]    speed_5;
  hts_pkg::phase_t       phase_now;

  modport source (output valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
                  phase_now, input ready);
  modport sink (input valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
                phase_now, output ready);
endinterface

>>> rtl/hts_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel: register index and data with valid/ready
// depends on hts_pkg
interface hts_cfg_if;
  logic               valid;
  logic               ready;
  hts_pkg::cfg_idx_t  index;
  hts_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/hexapod_tripod_gait_sequencer_unit.sv
`timescale 1ns / 1ps
// Every accepted transaction goes into an input register, and the window compares, the speed
// select and the phase update run from there into the result register, so the block takes
// one transaction per clock while the result register is not stalled; a result is offered
// as it reaches the result register; a stalled result register holds the input register.
// The gait phase, leg-done flags and last mode update as each transaction leaves the input
// register; a mode change restarts the gait at home. Configuration writes are taken at once
// and are meant to happen while no transaction is in flight.
// depends on hts_pkg, hts_in_if, hts_out_if, hts_cfg_if
module hexapod_tripod_gait_sequencer_unit (
  input logic         clk,
  input logic         rst_n,
  hts_in_if.sink      in_ch,
  hts_out_if.source   out_ch,
  hts_cfg_if.sink     cfg_ch
);
  import hts_pkg::*;

  // configuration
  land_t landing_r;
  mag_t  air_r;
  mag_t  ground_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      landing_r <= LANDING_RST;
      air_r     <= AIR_RST;
      ground_r  <= GROUND_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LANDING: landing_r <= cfg_ch.data[LAND_W-1:0];
        REG_AIR:     air_r     <= cfg_ch.data[MAG_W-1:0];
        REG_GROUND:  ground_r  <= cfg_ch.data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic   s1_v_r, s1_v_nxt;
  logic   out_v_r, out_v_nxt;
  logic   s1_adv;
  logic   in_fire;
  op_t    s1_op_r;
  angle_t s1_ang_r [NLEGS];

  assign s1_adv       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_ch.op;
      s1_ang_r[0] <= in_ch.angle_0;
      s1_ang_r[1] <= in_ch.angle_1;
      s1_ang_r[2] <= in_ch.angle_2;
      s1_ang_r[3] <= in_ch.angle_3;
      s1_ang_r[4] <= in_ch.angle_4;
      s1_ang_r[5] <= in_ch.angle_5;
    end
  end

  // gait state
  phase_t             phase_r, phase_nxt;
  logic [NLEGS-1:0]   done_r, done_nxt;
  op_t                last_mode_r;
  phase_t             eff_phase;
  logic [NLEGS-1:0]   eff_done;
  logic [NLEGS-1:0]   hit;
  plan_idx_t          mode_idx;
  plan_idx_t          phase_idx;
  plan_t              entry [NLEGS];
  speed_t             speed [NLEGS];
  mag_t               mag;
  logic               all_done;
  logic               mode_change;

  assign mode_change = s1_op_r != last_mode_r;

  always_comb begin
    eff_phase = mode_change ? PH_HOME : phase_r;
    eff_done  = mode_change ? '0 : done_r;
    case (s1_op_r)
      OP_LEFT:  mode_idx = IDX_0;
      OP_RIGHT: mode_idx = IDX_1;
      default:  mode_idx = IDX_2;
    endcase
    case (eff_phase)
      PH_HOME:  phase_idx = IDX_0;
      PH_TRI_A: phase_idx = IDX_1;
      default:  phase_idx = IDX_2;
    endcase
    done_nxt = eff_done;
    for (int i = 0; i < NLEGS; i++) begin
      entry[i] = PLAN[mode_idx][phase_idx][i];
      hit[i]   = in_window(entry[i].win, s1_ang_r[i], landing_r);
      mag      = (entry[i].spd == S_PA || entry[i].spd == S_NA) ? air_r : ground_r;
      if (s1_op_r == OP_STOP || hit[i]) begin
        speed[i] = '0;
      end else if (entry[i].spd == S_NA || entry[i].spd == S_NG) begin
        speed[i] = SPEED_W'(-{1'b0, mag});
      end else begin
        speed[i] = {1'b0, mag};
      end
      if (s1_op_r != OP_STOP && hit[i]) begin
        done_nxt[i] = 1'b1;
      end
    end
    // home needs legs 0 to 2 only, the stepping phases need all legs
    all_done = (phase_idx == IDX_0) ? &done_nxt[2:0] : &done_nxt;
    phase_nxt = eff_phase;
    if (s1_op_r != OP_STOP && all_done) begin
      done_nxt  = '0;
      phase_nxt = (phase_idx == IDX_1) ? PH_TRI_B : PH_TRI_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HOME;
      done_r      <= '0;
      last_mode_r <= OP_STOP;
    end else if (s1_adv) begin
      phase_r     <= phase_nxt;
      done_r      <= done_nxt;
      last_mode_r <= s1_op_r;
    end
  end

  // result register
  speed_t out_speed_r [NLEGS];
  phase_t out_phase_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < NLEGS; i++) begin
        out_speed_r[i] <= speed[i];
      end
      out_phase_r <= phase_nxt;
    end
  end

  assign out_ch.speed_0   = out_speed_r[0];
  assign out_ch.speed_1   = out_speed_r[1];
  assign out_ch.speed_2   = out_speed_r[2];
  assign out_ch.speed_3   = out_speed_r[3];
  assign out_ch.speed_4   = out_speed_r[4];
  assign out_ch.speed_5   = out_speed_r[5];
  assign out_ch.phase_now = out_phase_r;

  // checks
  a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd0)
    else $error("gait phase left the valid range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |-> !s1_adv)
    else $error("input stage advanced into a stalled result register");

  a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && s1_adv) |=> (out_phase_r == phase_r))
    else $error("reported phase differs from stored phase");

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && s1_adv && s1_op_r == OP_STOP && !mode_change) |=>
      ($stable(phase_r) && $stable(done_r)))
    else $error("stop transaction changed gait state");

endmodule
